### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the gap-fill aligner.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold while out of reset
`define QG_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// ante at one edge implies cons at the next edge
`define QG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/qgfa_pkg.sv
// Package of the gap-fill aligner: sizes, fill-mode codes, state enum, table entry.
// Depends on nothing; used by the top level, the checker and the testbench.
`default_nettype none
package qgfa_pkg;
  localparam int SYM_COUNT  = 256;
  localparam int IDX_W      = $clog2(SYM_COUNT);
  localparam int RATIO_BITS = 16;
  localparam int QW         = RATIO_BITS + 1;
  localparam int CNT_W      = $clog2(RATIO_BITS + 1);
  localparam int VW         = 49;               // widened price/volume
  localparam int PW         = VW + QW;          // full product width
  localparam int HI_W       = VW - 24;

  typedef enum logic [1:0] {
    MODE_SKIP     = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_LINEAR   = 2'd2,
    MODE_BACKWARD = 2'd3
  } fill_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DIV, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [47:0] volume;
    logic [47:0] close_p;
    logic [47:0] low_p;
    logic [47:0] high_p;
    logic [47:0] open_p;
    logic [39:0] bar_time;
  } known_t;

  localparam logic [2:0] CFG_ADDR_MODE = 3'd0;
endpackage
`default_nettype wire

### rtl/qgfa_ram.sv
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module qgfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

### rtl/quote_gap_fill_aligner.sv
// Gap-fill aligner: a store writes the table in its transfer cycle. An aligned, skip or
// backward bar goes straight to the result register; forward fill reads the stored bar
// first; linear fill then runs the divider (one quotient bit a cycle, none if the ratio
// clamps) and a split multiply per field. One item at a time: the input is ready in the
// cycle after the result loads, and the load waits while a previous result is held.
// Synchronous active-low reset clears the valid bits, the mode and the handshake state.
`default_nettype none
`include "assert_macros.svh"
module quote_gap_fill_aligner
  import qgfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // symbol, bar_time, open, high, low, close, volume, target_time
  input  wire logic [327:0] in_tdata,
  // cmd
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_symbol, out_time, out_open, out_high, out_low, out_close, out_volume
  output logic [287:0]      out_tdata,
  // close_missing
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  state_t state_r, state_nxt;
  fill_mode_t mode_r;
  logic [SYM_COUNT-1:0] valid_r;

  // input unpack
  logic [7:0]  i_sym;
  logic [39:0] i_bt, i_tt;
  known_t      i_bar;
  assign i_sym          = in_tdata[7:0];
  assign i_bt           = in_tdata[47:8];
  assign i_bar.bar_time = in_tdata[47:8];
  assign i_bar.open_p   = in_tdata[95:48];
  assign i_bar.high_p   = in_tdata[143:96];
  assign i_bar.low_p    = in_tdata[191:144];
  assign i_bar.close_p  = in_tdata[239:192];
  assign i_bar.volume   = in_tdata[287:240];
  assign i_tt           = in_tdata[327:288];

  logic in_fire, sym_in_table;
  logic [IDX_W-1:0] i_idx;
  assign in_fire      = in_tvalid && in_tready;
  assign sym_in_table = 32'(i_sym) < SYM_COUNT;
  assign i_idx        = IDX_W'(i_sym);

  // item registers
  logic [7:0]  sym_r;
  logic [39:0] tt_r;
  known_t      cur_r, kd_r, res_r;
  logic        miss_r;

  // table
  logic   ram_we;
  known_t ram_rdata;
  logic [$bits(known_t)-1:0] ram_q;
  assign ram_rdata = known_t'(ram_q);

  qgfa_ram #(.WIDTH($bits(known_t)), .DEPTH(SYM_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (i_idx),
    .wdata (i_bar),
    .rdata (ram_q)
  );

  // APB
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_MODE) ? {30'd0, mode_r} : 32'd0;

  // divider
  logic [40:0] rem_r, d_r;
  logic [QW-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic [41:0] rem2;
  assign rem2 = {rem_r, 1'b0};

  // ratio setup from stored time
  logic [40:0] num, den, n_abs, d_abs;
  logic ratio_pos, same_t;
  assign num       = {1'b0, tt_r} - {1'b0, ram_rdata.bar_time};
  assign den       = {1'b0, cur_r.bar_time} - {1'b0, ram_rdata.bar_time};
  assign n_abs     = num[40] ? -num : num;
  assign d_abs     = den[40] ? -den : den;
  assign ratio_pos = (num != '0) && (num[40] == den[40]);
  assign same_t    = cur_r.bar_time == ram_rdata.bar_time;

  // lerp, one field at a time
  logic [2:0] fld_r;
  logic       ph_r;
  logic [47:0] last_f, next_f;
  logic        is_vol;
  logic [VW-1:0] last_w, next_w, base, m, base_r;
  logic [QW-1:0] qq;
  logic [HI_W+QW-1:0] a_r;
  logic [24+QW-1:0]   b_r;
  logic [PW-1:0] prod;
  logic [VW-1:0] frac, lerp_v;

  always_comb begin
    last_f = kd_r.open_p;
    next_f = cur_r.open_p;
    unique case (fld_r)
      3'd0: begin last_f = kd_r.open_p;  next_f = cur_r.open_p;  end
      3'd1: begin last_f = kd_r.high_p;  next_f = cur_r.high_p;  end
      3'd2: begin last_f = kd_r.low_p;   next_f = cur_r.low_p;   end
      3'd3: begin last_f = kd_r.close_p; next_f = cur_r.close_p; end
      default: begin last_f = kd_r.volume; next_f = cur_r.volume; end
    endcase
  end

  assign is_vol = fld_r == 3'd4;
  assign last_w = {is_vol ? 1'b0 : last_f[47], last_f};
  assign next_w = {is_vol ? 1'b0 : next_f[47], next_f};

  always_comb begin
    if ($signed(next_w) >= $signed(last_w)) begin
      base = last_w;
      m    = next_w - last_w;
      qq   = q_r;
    end else begin
      base = next_w;
      m    = last_w - next_w;
      qq   = QW'(1 << RATIO_BITS) - q_r;
    end
  end

  assign prod   = (PW'(a_r) << 24) + PW'(b_r);
  assign frac   = VW'(prod >> RATIO_BITS);
  assign lerp_v = base_r + frac;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tuser[0]) begin
          if (i_bt == i_tt || mode_r == MODE_BACKWARD || mode_r == MODE_SKIP) begin
            state_nxt = ST_EMIT;
          end else if (sym_in_table && valid_r[i_idx]) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (mode_r == MODE_FORWARD || same_t) begin
          state_nxt = ST_EMIT;
        end else if (ratio_pos && n_abs < d_abs) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIV:  if (cnt_r == CNT_W'(RATIO_BITS - 1)) state_nxt = ST_MUL;
      ST_MUL:  if (ph_r && fld_r == 3'd4) state_nxt = ST_EMIT;
      ST_EMIT: if (!out_tvalid || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = state_r == ST_IDLE;
    ram_we    = in_fire && !in_tuser[0] && sym_in_table;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= MODE_SKIP;
      valid_r    <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == CFG_ADDR_MODE) begin
        mode_r <= fill_mode_t'(cfg_pwdata[1:0]);
      end
      if (ram_we) begin
        valid_r[i_idx] <= 1'b1;
      end
      if (state_r == ST_EMIT && (!out_tvalid || out_tready)) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          sym_r  <= i_sym;
          tt_r   <= i_tt;
          cur_r  <= i_bar;
          res_r  <= i_bar;
          miss_r <= 1'b0;
          if (!(i_bt == i_tt || mode_r == MODE_BACKWARD) && mode_r == MODE_SKIP) begin
            res_r.close_p <= '0;
            miss_r        <= 1'b1;
          end
        end
      end
      ST_READ: begin
        kd_r  <= ram_rdata;
        res_r <= ram_rdata;
        fld_r <= '0;
        ph_r  <= 1'b0;
        cnt_r <= '0;
        rem_r <= n_abs;
        d_r   <= d_abs;
        if (!ratio_pos) begin
          q_r <= '0;
        end else if (n_abs >= d_abs) begin
          q_r <= QW'(1 << RATIO_BITS);
        end else begin
          q_r <= '0;
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (rem2 >= {1'b0, d_r}) begin
          rem_r <= 41'(rem2 - {1'b0, d_r});
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem2[40:0];
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
      end
      ST_MUL: begin
        res_r.bar_time <= tt_r;
        if (!ph_r) begin
          // split the wide multiply into two partial products
          base_r <= base;
          a_r    <= m[VW-1:24] * qq;
          b_r    <= m[23:0] * qq;
          ph_r   <= 1'b1;
        end else begin
          ph_r  <= 1'b0;
          fld_r <= fld_r + 1'b1;
          unique case (fld_r)
            3'd0:    res_r.open_p  <= lerp_v[47:0];
            3'd1:    res_r.high_p  <= lerp_v[47:0];
            3'd2:    res_r.low_p   <= lerp_v[47:0];
            3'd3:    res_r.close_p <= lerp_v[47:0];
            default: res_r.volume  <= lerp_v[47:0];
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_tvalid || out_tready) begin
          out_tdata <= {res_r.volume, res_r.close_p, res_r.low_p, res_r.high_p,
                        res_r.open_p, res_r.bar_time, sym_r};
          out_tuser <= miss_r;
        end
      end
      default: ;
    endcase
  end

  `QG_ASSERT_NEXT(a_store_marks, in_fire && !in_tuser[0] && sym_in_table, valid_r[$past(i_idx)])
  `QG_ASSERT_NEVER(a_ratio_range, state_r == ST_MUL && q_r > QW'(1 << RATIO_BITS))
  `QG_ASSERT_NEVER(a_div_count, state_r == ST_DIV && cnt_r >= CNT_W'(RATIO_BITS))
  `QG_ASSERT_NEVER(a_fld_range, state_r == ST_MUL && fld_r > 3'd4)
endmodule
`default_nettype wire

### dv/qgfa_checker.sv
// Checker for the gap-fill aligner: watches the bar and result streams and the
// config port, predicts each result and compares it. Depends on qgfa_pkg.
`timescale 1ns / 1ps
module qgfa_checker
  import qgfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [327:0] in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending_bars,
  output int           bars_emitted
);
  localparam logic CMD_STORE = 1'b0;

  typedef struct packed {
    logic        missing;
    logic [47:0] volume;
    logic [47:0] close_p;
    logic [47:0] low_p;
    logic [47:0] high_p;
    logic [47:0] open_p;
    logic [39:0] bar_time;
    logic [7:0]  symbol;
  } aligned_bar_t;

  fill_mode_t   gap_mode;
  logic         have_bar [SYM_COUNT];
  known_t       last_bar [SYM_COUNT];
  aligned_bar_t expected_bars[$];

  assign pending_bars = expected_bars.size();

  // floor(last + (next - last) * q / 2^RATIO_BITS)
  function automatic logic [47:0] blend(logic signed [49:0] prev, logic signed [49:0] cur,
                                        logic [16:0] q);
    logic signed [49:0] span;
    logic [67:0] prod;
    if (cur >= prev) begin
      span = cur - prev;
      prod = span[49:0] * q;
      return 48'(prev + $signed({1'b0, prod[67:RATIO_BITS]}));
    end
    span = prev - cur;
    prod = span[49:0] * (17'h10000 - q);
    return 48'(cur + $signed({1'b0, prod[67:RATIO_BITS]}));
  endfunction

  task automatic predict_bar(input logic cmd, input logic [327:0] d);
    logic [7:0]  sym;
    logic [39:0] bt, tt;
    logic [47:0] op, hp, lp, cp, vol;
    known_t      k;
    aligned_bar_t r;
    logic signed [41:0] num, den;
    logic [40:0] n, dd, rem;
    logic [16:0] q;
    sym = d[7:0]; bt = d[47:8]; op = d[95:48]; hp = d[143:96];
    lp = d[191:144]; cp = d[239:192]; vol = d[287:240]; tt = d[327:288];
    if (cmd == CMD_STORE) begin
      have_bar[sym] = 1'b1;
      last_bar[sym] = '{volume: vol, close_p: cp, low_p: lp, high_p: hp,
                        open_p: op, bar_time: bt};
      return;
    end
    r = '{missing: 1'b0, volume: vol, close_p: cp, low_p: lp, high_p: hp,
          open_p: op, bar_time: bt, symbol: sym};
    if (bt == tt || gap_mode == MODE_BACKWARD) begin
      expected_bars.push_back(r);
      return;
    end
    if (gap_mode == MODE_SKIP) begin
      r.close_p = '0; r.missing = 1'b1;
      expected_bars.push_back(r);
      return;
    end
    if (!have_bar[sym]) return;
    k = last_bar[sym];
    if (gap_mode == MODE_FORWARD || bt == k.bar_time) begin
      r = '{missing: 1'b0, volume: k.volume, close_p: k.close_p, low_p: k.low_p,
            high_p: k.high_p, open_p: k.open_p, bar_time: k.bar_time, symbol: sym};
      expected_bars.push_back(r);
      return;
    end
    num = $signed({2'b0, tt}) - $signed({2'b0, k.bar_time});
    den = $signed({2'b0, bt}) - $signed({2'b0, k.bar_time});
    q = '0;
    if (num != 0 && ((num > 0) == (den > 0))) begin
      n = 41'(num < 0 ? -num : num);
      dd = 41'(den < 0 ? -den : den);
      if (n >= dd) q = 17'h10000;
      else begin
        rem = n;
        for (int i = 0; i < RATIO_BITS; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= dd) begin
            rem = rem - dd;
            q[0] = 1'b1;
          end
        end
      end
    end
    r.bar_time = tt;
    r.open_p  = blend(50'(signed'(k.open_p)),  50'(signed'(op)), q);
    r.high_p  = blend(50'(signed'(k.high_p)),  50'(signed'(hp)), q);
    r.low_p   = blend(50'(signed'(k.low_p)),   50'(signed'(lp)), q);
    r.close_p = blend(50'(signed'(k.close_p)), 50'(signed'(cp)), q);
    r.volume  = blend($signed({2'b0, k.volume}), $signed({2'b0, vol}), q);
    expected_bars.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    aligned_bar_t w;
    if (!rst_n) begin
      gap_mode <= MODE_SKIP;
      fail_count = 0;
      bars_emitted = 0;
      expected_bars.delete();
      for (int i = 0; i < SYM_COUNT; i++) have_bar[i] = 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == CFG_ADDR_MODE)
        gap_mode <= fill_mode_t'(cfg_pwdata[1:0]);
      if (out_tvalid && out_tready) begin
        bars_emitted++;
        if (expected_bars.size() == 0) begin
          $error("unexpected result transfer, symbol %h", out_tdata[7:0]);
          fail_count++;
        end else begin
          w = expected_bars.pop_front();
          compare_field("out_symbol", w.symbol, out_tdata[7:0]);
          compare_field("out_time", w.bar_time, out_tdata[47:8]);
          compare_field("out_open", w.open_p, out_tdata[95:48]);
          compare_field("out_high", w.high_p, out_tdata[143:96]);
          compare_field("out_low", w.low_p, out_tdata[191:144]);
          compare_field("out_close", w.close_p, out_tdata[239:192]);
          compare_field("out_volume", w.volume, out_tdata[287:240]);
          compare_field("close_missing", w.missing, out_tuser[0]);
        end
      end
      if (in_tvalid && in_tready) predict_bar(in_tuser[0], in_tdata);
    end
  end
endmodule

### dv/tb_quote_gap_fill_aligner.sv
// Testbench top of the gap-fill aligner: drives bars, config writes and stalls,
// gives the verdict. Depends on qgfa_pkg, the RTL and qgfa_checker.
`timescale 1ns / 1ps
module tb_quote_gap_fill_aligner;
  import qgfa_pkg::*;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_ALIGN = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [327:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count, pending_bars, bars_emitted;
  int           cycles = 0, bars_sent = 0;
  logic [39:0]  round_time;

  quote_gap_fill_aligner dut (.*);

  qgfa_checker u_checker (.*);

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quote_gap_fill_aligner: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
  end

  task automatic write_mode(input fill_mode_t m);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= CFG_ADDR_MODE;
    cfg_pwdata <= {30'b0, m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // hold valid across back-to-back transfers; drop it only for a gap
  task automatic send_bar(input logic cmd, input logic [7:0] sym, input logic [39:0] bt,
                          input logic [47:0] op, input logic [47:0] hp,
                          input logic [47:0] lp, input logic [47:0] cp,
                          input logic [47:0] vol, input logic [39:0] tt);
    int g;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {tt, vol, cp, lp, hp, op, bt, sym};
    do @(posedge clk); while (!in_tready);
    bars_sent++;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [47:0] near_price(input logic [47:0] base);
    if ($urandom_range(0, 9) == 0) return rand48();
    return base + 48'(signed'(32'($urandom_range(0, 2000000)) - 32'sd1000000));
  endfunction

  task automatic random_bar(input logic cmd, input logic [7:0] sym);
    logic [39:0] bt;
    logic [47:0] p;
    bt = round_time + 40'($urandom_range(0, 600)) - 40'd300;
    if ($urandom_range(0, 4) == 0) bt = round_time;
    if ($urandom_range(0, 19) == 0) bt = {8'($urandom), $urandom};
    p = ($urandom_range(0, 9) == 0) ? rand48() : 48'($urandom_range(0, 50000000));
    send_bar(cmd, sym, bt, near_price(p), near_price(p), near_price(p), near_price(p),
             ($urandom_range(0, 9) == 0) ? rand48() : 48'($urandom), round_time);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_bars != 0) @(posedge clk);
    // linear fill is the slowest path and may still be busy on a silent item
    repeat (40) @(posedge clk);
  endtask

  localparam logic [47:0] PMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] PMIN = 48'h8000_0000_0000;
  localparam logic [47:0] UMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] TMAX = 40'hFF_FFFF_FFFF;

  initial begin
    fill_mode_t modes[4];
    modes = '{MODE_SKIP, MODE_FORWARD, MODE_LINEAR, MODE_BACKWARD};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // skip mode at reset value: aligned and misaligned
    send_bar(CMD_ALIGN, 8'd0, 40'd100, PMAX, PMIN, 48'd0, PMAX, UMAX, 40'd100);
    send_bar(CMD_ALIGN, 8'hFF, TMAX, PMIN, PMAX, UMAX, PMIN, 48'd0, 40'd0);
    drain();
    // forward and linear without a stored bar emit nothing
    write_mode(MODE_FORWARD);
    send_bar(CMD_ALIGN, 8'd7, 40'd5, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1, 40'd9);
    send_bar(CMD_STORE, 8'd7, 40'd0, PMIN, PMAX, 48'd0, PMIN, UMAX, 40'd0);
    send_bar(CMD_STORE, 8'hFF, TMAX, PMAX, PMIN, PMAX, PMAX, 48'd0, TMAX);
    send_bar(CMD_ALIGN, 8'd7, 40'd5, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1, 40'd9);
    drain();
    write_mode(MODE_LINEAR);
    send_bar(CMD_ALIGN, 8'd8, 40'd5, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1, 40'd9);
    // ratio inside, clamped at one, equal stored time, extremes
    send_bar(CMD_ALIGN, 8'd7, 40'd1000, PMAX, PMIN, PMAX, 48'd12345, 48'd0, 40'd333);
    send_bar(CMD_ALIGN, 8'd7, 40'd10, PMAX, PMIN, PMAX, PMAX, 48'd0, 40'd50);
    send_bar(CMD_ALIGN, 8'hFF, 40'd10, PMIN, PMAX, PMIN, 48'd0, UMAX, 40'd20);
    send_bar(CMD_ALIGN, 8'd7, 40'd0, 48'd9, 48'd9, 48'd9, 48'd9, 48'd9, 40'd77);
    send_bar(CMD_ALIGN, 8'hFF, 40'd0, PMIN, PMAX, PMIN, PMAX, UMAX, TMAX - 1);
    send_bar(CMD_ALIGN, 8'd7, TMAX, PMAX, PMIN, PMAX, PMIN, UMAX, 40'd1);
    drain();
    write_mode(MODE_BACKWARD);
    send_bar(CMD_ALIGN, 8'd3, 40'd1, PMIN, PMAX, PMIN, PMAX, UMAX, 40'd2);
    drain();

    // random rounds: stores and aligns mixed per round, modes cycled then random
    for (int ph = 0; ph < 12; ph++) begin
      write_mode(ph < 4 ? modes[ph] : fill_mode_t'($urandom_range(0, 3)));
      for (int rd = 0; rd < 5; rd++) begin
        round_time = ($urandom_range(0, 9) == 0) ? {8'($urandom), $urandom}
                                                 : 40'($urandom_range(1000, 100000));
        for (int i = 0; i < 15; i++) begin
          logic [7:0] s;
          s = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
          if ($urandom_range(0, 2) == 0) random_bar(CMD_STORE, s);
          else random_bar(CMD_ALIGN, s);
        end
      end
      drain();
    end
    $display("covered %0d bar transfers and %0d result transfers over four fill modes",
             bars_sent, bars_emitted);
    if (fail_count == 0) $display("tb_quote_gap_fill_aligner: PASS");
    else $display("tb_quote_gap_fill_aligner: FAIL");
    $finish;
  end
endmodule
